// ===== src/hsd_pkg.sv =====
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared constants for the Huffman stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hsd_pkg;

  localparam int NODE_COUNT_DEF  = 512;
  localparam int STACK_DEPTH_DEF = 256;

  localparam int LEN_W = 13;
  localparam int PAD_W = 3;
  localparam int SYM_W = 8;

  localparam logic [7:0] MARK_INTERNAL = 8'h2A;
  localparam logic [7:0] MARK_ESCAPE   = 8'h5C;

endpackage

`default_nettype wire

// ===== src/hsd_ram.sv =====
// ----------------------------------------------------------------------------
// hsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hsd_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = $clog2(D)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/hsd_queue.sv =====
// ----------------------------------------------------------------------------
// hsd_queue
// Two-entry queue of data bytes between the front and the walker.
// ----------------------------------------------------------------------------
`default_nettype none

module hsd_queue #(
  parameter int W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic      [W-1:0] data_o,
  output logic              empty_o
);

  logic [W-1:0] mem_q [2];
  logic [1:0]   cnt_q;
  logic         wr_q;
  logic         rd_q;
  logic         do_push;
  logic         do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/hsd_front.sv =====
// ----------------------------------------------------------------------------
// hsd_front
// Accepts bytes, parses the header, builds the node table, queues data bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module hsd_front import hsd_pkg::*; #(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int NW          = $clog2(NODE_COUNT),
  parameter int CW          = $clog2(NODE_COUNT + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [7:0]       byte_value_i,
  input  wire logic             is_last_byte_i,
  input  wire logic             back_quiet_i,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output logic      [PAD_W-1:0] q_pad_o,
  output logic      [CW-1:0]    q_nf_o,
  output logic                  node_we_o,
  output logic      [NW-1:0]    node_waddr_o,
  output logic      [SYM_W:0]   node_wdata_o,
  output logic                  left_we_o,
  output logic                  right_we_o,
  output logic      [NW-1:0]    child_waddr_o,
  output logic      [NW-1:0]    child_wdata_o
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);

  localparam logic [1:0] PH_HDR0 = 2'd0;
  localparam logic [1:0] PH_HDR1 = 2'd1;
  localparam logic [1:0] PH_TREE = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  logic [1:0]       phase_q;
  logic [PAD_W-1:0] pad_q;
  logic [LEN_W-1:0] tbl_q;
  logic             esc_q;
  logic [CW-1:0]    nf_q;
  logic [SPW-1:0]   sp_q;
  logic [NW-1:0]    top_idx_q;
  logic             top_ld_q;
  logic             link_q;
  logic             link_v_q;
  logic             link_side_q;
  logic [NW-1:0]    link_par_q;
  logic [NW-1:0]    link_n_q;
  logic             pop_ld_q;

  logic             acc;
  logic [LEN_W-1:0] tbl_dec;
  logic [LEN_W-1:0] tbl_hdr;
  logic             tdone;
  logic             is_int;
  logic             is_esc;
  logic             create;
  logic [NW-1:0]    n;
  logic             link;
  logic             pop;
  logic [SPW-1:0]   sp1;
  logic [SPW-1:0]   spm1;
  logic [SPW-1:0]   spm2;
  logic             push;
  logic             ld1;
  logic             stk_we;
  logic [NW:0]      stk_rdata;

  assign in_stall_o = link_q
                    | ((phase_q == PH_TREE) & ~back_quiet_i)
                    | ((phase_q == PH_DATA) & q_full_i);
  assign acc = in_valid_i & ~in_stall_o;

  assign tbl_dec = (tbl_q != '0) ? tbl_q - LEN_W'(1) : tbl_q;
  assign tbl_hdr = {tbl_q[4:0], byte_value_i};
  assign tdone   = (nf_q != '0) && (sp_q == '0);
  assign is_int  = !esc_q && (byte_value_i == MARK_INTERNAL);
  assign is_esc  = !esc_q && (byte_value_i == MARK_ESCAPE);
  assign create  = acc && (phase_q == PH_TREE) && !tdone && !is_esc
                && (nf_q < CW'(NODE_COUNT));
  assign n       = nf_q[NW-1:0];
  assign link    = (n != '0) && (sp_q != '0);
  assign pop     = link && top_ld_q;
  assign spm1    = sp_q - SPW'(1);
  assign spm2    = sp_q - SPW'(2);
  assign sp1     = pop ? spm1 : sp_q;
  assign push    = is_int && (sp1 < SPW'(STACK_DEPTH));
  assign ld1     = link | top_ld_q;
  assign stk_we  = create && push && !pop && (sp_q != '0);

  hsd_ram #(.W(NW + 1), .D(STACK_DEPTH)) u_stack (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(spm1[SAW-1:0]),
    .wdata_i({ld1, top_idx_q}),
    .raddr_i(spm2[SAW-1:0]),
    .rdata_o(stk_rdata)
  );

  assign node_we_o     = create;
  assign node_waddr_o  = n;
  assign node_wdata_o  = {!is_int, is_int ? 8'h00 : byte_value_i};
  assign left_we_o     = create | (link_v_q & ~link_side_q);
  assign right_we_o    = create | (link_v_q & link_side_q);
  assign child_waddr_o = link_v_q ? link_par_q : n;
  assign child_wdata_o = link_v_q ? link_n_q : '0;

  assign q_push_o = acc && (phase_q == PH_DATA);
  assign q_pad_o  = pad_q;
  assign q_nf_o   = nf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HDR0;
      pad_q       <= '0;
      tbl_q       <= '0;
      esc_q       <= 1'b0;
      nf_q        <= '0;
      sp_q        <= '0;
      top_idx_q   <= '0;
      top_ld_q    <= 1'b0;
      link_q      <= 1'b0;
      link_v_q    <= 1'b0;
      link_side_q <= 1'b0;
      link_par_q  <= '0;
      link_n_q    <= '0;
      pop_ld_q    <= 1'b0;
    end else begin
      link_q      <= acc && (phase_q == PH_TREE);
      link_v_q    <= create && link;
      link_side_q <= top_ld_q;
      link_par_q  <= top_idx_q;
      link_n_q    <= n;
      pop_ld_q    <= create && pop && !push && (sp_q > SPW'(1));
      if (link_q && pop_ld_q) begin
        top_idx_q <= stk_rdata[NW-1:0];
        top_ld_q  <= stk_rdata[NW];
      end
      if (acc) begin
        unique case (phase_q)
          PH_HDR0: begin
            pad_q   <= byte_value_i[7:5];
            tbl_q   <= {8'h00, byte_value_i[4:0]};
            phase_q <= PH_HDR1;
          end
          PH_HDR1: begin
            tbl_q   <= tbl_hdr;
            phase_q <= (tbl_hdr == '0) ? PH_DATA : PH_TREE;
          end
          PH_TREE: begin
            tbl_q <= tbl_dec;
            if (!tdone) begin
              if (esc_q) begin
                esc_q <= 1'b0;
              end else if (is_esc) begin
                esc_q <= 1'b1;
              end
            end
            if (create) begin
              nf_q <= nf_q + CW'(1);
              if (push) begin
                top_idx_q <= n;
                top_ld_q  <= 1'b0;
                if (!pop) begin
                  sp_q <= sp_q + SPW'(1);
                end
              end else if (pop) begin
                sp_q <= spm1;
              end else begin
                top_ld_q <= ld1;
              end
            end
            if (tbl_dec == '0) begin
              phase_q <= PH_DATA;
              esc_q   <= 1'b0;
            end
          end
          default: begin
          end
        endcase
        if (is_last_byte_i) begin
          phase_q <= PH_HDR0;
          pad_q   <= '0;
          tbl_q   <= '0;
          esc_q   <= 1'b0;
          nf_q    <= '0;
          sp_q    <= '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/hsd_back.sv =====
// ----------------------------------------------------------------------------
// hsd_back
// Walks the node table bit by bit for each queued data byte, emits symbols.
// ----------------------------------------------------------------------------
`default_nettype none

module hsd_back import hsd_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int NW         = $clog2(NODE_COUNT),
  parameter int CW         = $clog2(NODE_COUNT + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_empty_i,
  output logic                  q_pop_o,
  input  wire logic [7:0]       q_byte_i,
  input  wire logic             q_last_i,
  input  wire logic [PAD_W-1:0] q_pad_i,
  input  wire logic [CW-1:0]    q_nf_i,
  output logic      [NW-1:0]    raddr_o,
  input  wire logic [SYM_W:0]   node_rdata_i,
  input  wire logic [NW-1:0]    left_rdata_i,
  input  wire logic [NW-1:0]    right_rdata_i,
  output logic                  idle_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [SYM_W-1:0] symbol_o,
  output logic                  last_of_run_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_EV1   = 3'd2;
  localparam logic [2:0] S_EV2   = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]       st_q;
  logic [7:0]       byte_q;
  logic             last_q;
  logic [CW-1:0]    nf_q;
  logic [3:0]       nb_q;
  logic [2:0]       j_q;
  logic [NW-1:0]    cur_q;
  logic [NW-1:0]    child_q;
  logic             pend_v_q;
  logic [SYM_W-1:0] pend_sym_q;
  logic             out_v_q;
  logic [SYM_W-1:0] out_sym_q;
  logic             out_last_q;

  logic             out_free;
  logic             can_emit;
  logic [NW-1:0]    a;
  logic             leaf;
  logic             bit_v;
  logic [NW-1:0]    ch_raw;
  logic [NW-1:0]    ch;
  logic             last_bit;
  logic             ev2_emit;
  logic [3:0]       nb_new;

  assign out_free = !out_v_q || !out_stall_i;
  assign can_emit = !pend_v_q || out_free;
  assign a        = (CW'(cur_q) >= nf_q) ? '0 : cur_q;
  assign leaf     = node_rdata_i[SYM_W];
  assign bit_v    = byte_q[3'd7 - j_q];
  assign ch_raw   = bit_v ? right_rdata_i : left_rdata_i;
  assign ch       = (CW'(ch_raw) >= nf_q) ? '0 : ch_raw;
  assign last_bit = (({1'b0, j_q} + 4'd1) == nb_q);
  assign ev2_emit = (child_q != '0) && leaf;
  assign nb_new   = (q_nf_i == '0) ? 4'd0 : (q_last_i ? 4'd8 - {1'b0, q_pad_i} : 4'd8);

  assign q_pop_o       = (st_q == S_IDLE) && !q_empty_i;
  assign idle_o        = (st_q == S_IDLE);
  assign out_valid_o   = out_v_q;
  assign symbol_o      = out_sym_q;
  assign last_of_run_o = out_last_q;

  always_comb begin
    unique case (st_q)
      S_EV1:   raddr_o = leaf ? a : ch;
      S_EV2:   raddr_o = child_q;
      default: raddr_o = a;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      byte_q     <= '0;
      last_q     <= 1'b0;
      nf_q       <= '0;
      nb_q       <= '0;
      j_q        <= '0;
      cur_q      <= '0;
      child_q    <= '0;
      pend_v_q   <= 1'b0;
      pend_sym_q <= '0;
      out_v_q    <= 1'b0;
      out_sym_q  <= '0;
      out_last_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_v_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            byte_q <= q_byte_i;
            last_q <= q_last_i;
            nf_q   <= q_nf_i;
            nb_q   <= nb_new;
            j_q    <= '0;
            st_q   <= (nb_new == 4'd0) ? S_FLUSH : S_FETCH;
          end
        end
        S_FETCH: begin
          st_q <= S_EV1;
        end
        S_EV1: begin
          if (leaf) begin
            if (can_emit) begin
              if (pend_v_q) begin
                out_v_q    <= 1'b1;
                out_sym_q  <= pend_sym_q;
                out_last_q <= 1'b0;
              end
              pend_v_q   <= 1'b1;
              pend_sym_q <= node_rdata_i[SYM_W-1:0];
              cur_q      <= '0;
              j_q        <= j_q + 3'd1;
              st_q       <= last_bit ? S_FLUSH : S_FETCH;
            end
          end else begin
            child_q <= ch;
            st_q    <= S_EV2;
          end
        end
        S_EV2: begin
          if (ev2_emit) begin
            if (can_emit) begin
              if (pend_v_q) begin
                out_v_q    <= 1'b1;
                out_sym_q  <= pend_sym_q;
                out_last_q <= 1'b0;
              end
              pend_v_q   <= 1'b1;
              pend_sym_q <= node_rdata_i[SYM_W-1:0];
              cur_q      <= '0;
              j_q        <= j_q + 3'd1;
              st_q       <= last_bit ? S_FLUSH : S_FETCH;
            end
          end else begin
            cur_q <= child_q;
            j_q   <= j_q + 3'd1;
            st_q  <= last_bit ? S_FLUSH : S_EV1;
          end
        end
        S_FLUSH: begin
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              out_v_q    <= 1'b1;
              out_sym_q  <= pend_sym_q;
              out_last_q <= 1'b1;
              pend_v_q   <= 1'b0;
            end
            if (last_q) begin
              cur_q <= '0;
            end
            st_q <= S_IDLE;
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE) |-> !pend_v_q)
    else $error("held symbol left over at byte end");
  a_nb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> (nb_q <= 4'd8))
    else $error("bit count out of range");
  a_child_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_EV2) |-> (CW'(child_q) < nf_q))
    else $error("child index beyond node count");
  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (st_q == S_FETCH || st_q == S_FLUSH))
    else $error("queue pop without byte start");
`endif

endmodule

`default_nettype wire

// ===== src/huffman_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// huffman_stream_decoder
// Decodes a Huffman-compressed byte stream with a preorder tree header.
// ----------------------------------------------------------------------------
// A header byte or a data byte is accepted when the queue has room; a tree
// byte stalls the input while its child link is written and waits until all
// earlier data bytes are decoded. The walker loads a byte, fetches the entry
// it starts from and closes it in separate states; each code bit is resolved
// through the node table's registered read, and the root is fetched again
// when a bit steps from an internal node onto a leaf. The walk slows while
// the output stalls.
`default_nettype none

module huffman_stream_decoder import hsd_pkg::*; #(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [7:0]       byte_value_i,
  input  wire logic             is_last_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [SYM_W-1:0] symbol_o,
  output logic                  last_of_run_o
);

  localparam int NW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(NODE_COUNT + 1);
  localparam int QW = 8 + 1 + PAD_W + CW;

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  logic [PAD_W-1:0] q_pad_in;
  logic [CW-1:0]    q_nf_in;
  logic [QW-1:0]    q_out;
  logic             node_we;
  logic [NW-1:0]    node_waddr;
  logic [SYM_W:0]   node_wdata;
  logic             left_we;
  logic             right_we;
  logic [NW-1:0]    child_waddr;
  logic [NW-1:0]    child_wdata;
  logic [NW-1:0]    raddr;
  logic [SYM_W:0]   node_rdata;
  logic [NW-1:0]    left_rdata;
  logic [NW-1:0]    right_rdata;
  logic             back_idle;

  hsd_front #(.NODE_COUNT(NODE_COUNT), .STACK_DEPTH(STACK_DEPTH)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .byte_value_i  (byte_value_i),
    .is_last_byte_i(is_last_byte_i),
    .back_quiet_i  (back_idle & q_empty),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_pad_o       (q_pad_in),
    .q_nf_o        (q_nf_in),
    .node_we_o     (node_we),
    .node_waddr_o  (node_waddr),
    .node_wdata_o  (node_wdata),
    .left_we_o     (left_we),
    .right_we_o    (right_we),
    .child_waddr_o (child_waddr),
    .child_wdata_o (child_wdata)
  );

  hsd_ram #(.W(SYM_W + 1), .D(NODE_COUNT)) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (node_we),
    .waddr_i(node_waddr),
    .wdata_i(node_wdata),
    .raddr_i(raddr),
    .rdata_o(node_rdata)
  );

  hsd_ram #(.W(NW), .D(NODE_COUNT)) u_left_ram (
    .clk_i  (clk_i),
    .we_i   (left_we),
    .waddr_i(child_waddr),
    .wdata_i(child_wdata),
    .raddr_i(raddr),
    .rdata_o(left_rdata)
  );

  hsd_ram #(.W(NW), .D(NODE_COUNT)) u_right_ram (
    .clk_i  (clk_i),
    .we_i   (right_we),
    .waddr_i(child_waddr),
    .wdata_i(child_wdata),
    .raddr_i(raddr),
    .rdata_o(right_rdata)
  );

  hsd_queue #(.W(QW)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i ({q_nf_in, q_pad_in, is_last_byte_i, byte_value_i}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_out),
    .empty_o(q_empty)
  );

  hsd_back #(.NODE_COUNT(NODE_COUNT)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .q_byte_i     (q_out[7:0]),
    .q_last_i     (q_out[8]),
    .q_pad_i      (q_out[9 +: PAD_W]),
    .q_nf_i       (q_out[9 + PAD_W +: CW]),
    .raddr_o      (raddr),
    .node_rdata_i (node_rdata),
    .left_rdata_i (left_rdata),
    .right_rdata_i(right_rdata),
    .idle_o       (back_idle),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .symbol_o     (symbol_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

`default_nettype wire
